// ===== rtl/hysteresis_threshold_3x3_top_assert.svh =====
// Assertion macros for the hysteresis threshold block checker.
// Depends on a clock named clk and a reset named rst in the using scope.
`ifndef HYSTERESIS_THRESHOLD_3X3_TOP_ASSERT_SVH
`define HYSTERESIS_THRESHOLD_3X3_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HT3_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("hysteresis threshold check failed");

// Next-cycle implication, disabled during reset.
`define HT3_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("hysteresis threshold check failed");

// Next-cycle implication that also holds across reset.
`define HT3_ASSERT_ALWAYS(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("hysteresis threshold check failed");

`endif

// ===== rtl/hyst3_pkg.sv =====
// Shared types, constants and the pixel classifier of the hysteresis threshold block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hyst3_pkg;

  localparam int MAX_LINE_LENGTH = 1024;
  localparam int MAX_LINE_COUNT  = 4096;

  localparam int PIX_W    = 8;
  localparam int LEN_W    = $clog2(MAX_LINE_LENGTH) + 1;   // holds MAX_LINE_LENGTH itself
  localparam int CNT_W    = $clog2(MAX_LINE_COUNT) + 1;
  localparam int COL_W    = $clog2(MAX_LINE_LENGTH);
  localparam int ROW_W    = $clog2(MAX_LINE_COUNT);
  localparam int IN_ROW_W = ROW_W + 2;                     // saturating, may run past the frame
  localparam int CFG_W    = CNT_W;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_LOW_THRESHOLD  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_THRESHOLD = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LINE_LENGTH    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_LINE_COUNT     = 2'd3;

  localparam logic [PIX_W-1:0] RST_LOW_THRESHOLD  = 8'd64;
  localparam logic [PIX_W-1:0] RST_HIGH_THRESHOLD = 8'd192;
  localparam logic [LEN_W-1:0] RST_LINE_LENGTH    = LEN_W'(1024);
  localparam logic [CNT_W-1:0] RST_LINE_COUNT     = CNT_W'(1024);

  localparam logic [PIX_W-1:0] PIX_FULL   = 8'd255;
  localparam logic [PIX_W-1:0] EDGE_VALUE = 8'd0;
  localparam logic [PIX_W-1:0] BACK_VALUE = 8'd255;

  localparam int OBUF_DEPTH = 3;

  typedef enum logic [1:0] {
    CLS_LOW    = 2'd0,
    CLS_WEAK   = 2'd1,
    CLS_STRONG = 2'd2
  } cls_t;

  localparam int CLS_W  = 2;
  localparam int LINE_W = 2 * CLS_W;   // {two lines up, one line up}

  // One line-buffer request from the position tracker to the window stage.
  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] col;
    cls_t             cls;
    logic             emit;
    logic             top;
    logic             bottom;
    logic             left;
    logic             right;
    logic             last;
  } req_t;

  function automatic cls_t classify(input logic [PIX_W-1:0] v,
                                    input logic [PIX_W-1:0] lo,
                                    input logic [PIX_W-1:0] hi);
    cls_t c;
    if (v < lo) c = CLS_LOW;
    else if (v > hi || v == PIX_FULL) c = CLS_STRONG;
    else c = CLS_WEAK;
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hyst3_line_ram.sv =====
// Simple dual-port line RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module hyst3_line_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hyst3_pos.sv =====
// Input and output position tracking, pixel classing and border flags.
// Depends on hyst3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hyst3_pos (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         accept,
  input  wire logic                         mode,
  input  wire logic [hyst3_pkg::PIX_W-1:0]  pixel_value,
  input  wire logic [hyst3_pkg::PIX_W-1:0]  low_threshold,
  input  wire logic [hyst3_pkg::PIX_W-1:0]  high_threshold,
  input  wire logic [hyst3_pkg::LEN_W-1:0]  line_length,
  input  wire logic [hyst3_pkg::CNT_W-1:0]  line_count,
  output hyst3_pkg::req_t                   req
);

  logic [hyst3_pkg::COL_W-1:0]    in_column;
  logic [hyst3_pkg::IN_ROW_W-1:0] in_row;
  logic [hyst3_pkg::COL_W-1:0]    out_column;
  logic [hyst3_pkg::ROW_W-1:0]    out_row;

  logic [hyst3_pkg::COL_W-1:0]    in_column_next;
  logic [hyst3_pkg::IN_ROW_W-1:0] in_row_next;
  logic [hyst3_pkg::COL_W-1:0]    out_column_next;
  logic [hyst3_pkg::ROW_W-1:0]    out_row_next;

  logic [hyst3_pkg::LEN_W-1:0] eff_len;
  logic [hyst3_pkg::CNT_W-1:0] eff_cnt;
  logic [hyst3_pkg::LEN_W-1:0] in_col_sum;
  logic [hyst3_pkg::LEN_W-1:0] out_col_sum;
  logic [hyst3_pkg::CNT_W-1:0] out_row_sum;
  logic                        skip;
  logic                        primed;
  logic                        in_wrap;
  logic                        out_col_wrap;
  logic                        out_row_wrap;
  logic                        frame_end;
  hyst3_pkg::cls_t             cls;

  always_comb begin
    if (line_length == '0) eff_len = hyst3_pkg::LEN_W'(1);
    else if (line_length > hyst3_pkg::LEN_W'(hyst3_pkg::MAX_LINE_LENGTH))
      eff_len = hyst3_pkg::LEN_W'(hyst3_pkg::MAX_LINE_LENGTH);
    else eff_len = line_length;

    if (line_count == '0) eff_cnt = hyst3_pkg::CNT_W'(1);
    else if (line_count > hyst3_pkg::CNT_W'(hyst3_pkg::MAX_LINE_COUNT))
      eff_cnt = hyst3_pkg::CNT_W'(hyst3_pkg::MAX_LINE_COUNT);
    else eff_cnt = line_count;
  end

  // Flush before the first pixel of a frame: drop it without a trace.
  assign skip   = mode && (in_row == '0) && (in_column == '0);
  assign primed = (in_row >= hyst3_pkg::IN_ROW_W'(2)) ||
                  ((in_row == hyst3_pkg::IN_ROW_W'(1)) && (in_column != '0));

  always_comb begin
    if (!mode && (in_row < hyst3_pkg::IN_ROW_W'(eff_cnt)))
      cls = hyst3_pkg::classify(pixel_value, low_threshold, high_threshold);
    else
      cls = hyst3_pkg::CLS_LOW;
  end

  assign in_col_sum   = {1'b0, in_column} + hyst3_pkg::LEN_W'(1);
  assign in_wrap      = in_col_sum >= eff_len;
  assign out_col_sum  = {1'b0, out_column} + hyst3_pkg::LEN_W'(1);
  assign out_col_wrap = out_col_sum >= eff_len;
  assign out_row_sum  = {1'b0, out_row} + hyst3_pkg::CNT_W'(1);
  assign out_row_wrap = out_row_sum >= eff_cnt;
  assign frame_end    = primed && out_col_wrap && out_row_wrap;

  always_comb begin
    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    if (in_wrap) begin
      in_column_next = '0;
      if (in_row != '1) in_row_next = in_row + hyst3_pkg::IN_ROW_W'(1);
    end else begin
      in_column_next = in_col_sum[hyst3_pkg::COL_W-1:0];
    end
    if (primed) begin
      if (out_col_wrap) begin
        out_column_next = '0;
        out_row_next    = out_row_wrap ? '0 : out_row_sum[hyst3_pkg::ROW_W-1:0];
      end else begin
        out_column_next = out_col_sum[hyst3_pkg::COL_W-1:0];
      end
    end
    if (frame_end) begin
      in_column_next = '0;
      in_row_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (accept && !skip) begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
    end
  end

  always_comb begin
    req.valid  = accept && !skip;
    req.col    = in_column;
    req.cls    = cls;
    req.emit   = primed;
    req.top    = (out_row == '0);
    req.bottom = out_row_wrap;
    req.left   = (out_column == '0);
    req.right  = out_col_wrap;
    req.last   = frame_end;
  end

endmodule
`default_nettype wire

// ===== rtl/hyst3_win.sv =====
// Line-buffer read-modify-write stage, 3x3 class window and edge decision.
// Depends on hyst3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hyst3_win (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire hyst3_pkg::req_t               req,
  input  wire logic [hyst3_pkg::LINE_W-1:0]  ram_rdata,
  output logic                               ram_we,
  output logic      [hyst3_pkg::COL_W-1:0]   ram_waddr,
  output logic      [hyst3_pkg::LINE_W-1:0]  ram_wdata,
  output logic                               push,
  output logic      [hyst3_pkg::PIX_W-1:0]   push_value,
  output logic                               push_last
);

  hyst3_pkg::req_t s1;
  logic            fwd_hit;
  logic [hyst3_pkg::LINE_W-1:0] fwd_data;
  logic [hyst3_pkg::LINE_W-1:0] entry;
  hyst3_pkg::cls_t win [3][3];     // [column, oldest first][row, top first]
  hyst3_pkg::cls_t nw  [3][3];
  hyst3_pkg::cls_t above2;
  hyst3_pkg::cls_t above1;
  logic            strong_near;
  logic            is_edge;

  // Take the line entry from the write that lands in the same cycle as its read.
  assign entry  = fwd_hit ? fwd_data : ram_rdata;
  assign above2 = hyst3_pkg::cls_t'(entry[hyst3_pkg::LINE_W-1:hyst3_pkg::CLS_W]);
  assign above1 = hyst3_pkg::cls_t'(entry[hyst3_pkg::CLS_W-1:0]);

  assign ram_we    = s1.valid;
  assign ram_waddr = s1.col;
  assign ram_wdata = {above1, s1.cls};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      s1.valid <= req.valid;
      fwd_hit  <= req.valid && s1.valid && (req.col == s1.col);
    end
    s1.col    <= req.col;
    s1.cls    <= req.cls;
    s1.emit   <= req.emit;
    s1.top    <= req.top;
    s1.bottom <= req.bottom;
    s1.left   <= req.left;
    s1.right  <= req.right;
    s1.last   <= req.last;
    fwd_data  <= ram_wdata;
  end

  always_comb begin
    for (int z = 0; z < 3; z++) begin
      nw[0][z] = win[1][z];
      nw[1][z] = win[2][z];
    end
    nw[2][0] = above2;
    nw[2][1] = above1;
    nw[2][2] = s1.cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        for (int z = 0; z < 3; z++) begin
          win[k][z] <= hyst3_pkg::CLS_LOW;
        end
      end
    end else if (s1.valid) begin
      for (int k = 0; k < 3; k++) begin
        for (int z = 0; z < 3; z++) begin
          win[k][z] <= nw[k][z];
        end
      end
    end
  end

  // Neighbors outside the frame are masked; border replication gives the same.
  always_comb begin
    strong_near = 1'b0;
    for (int k = 0; k < 3; k++) begin
      for (int z = 0; z < 3; z++) begin
        if (!(k == 1 && z == 1) &&
            !(k == 0 && s1.left) && !(k == 2 && s1.right) &&
            !(z == 0 && s1.top) && !(z == 2 && s1.bottom) &&
            (nw[k][z] == hyst3_pkg::CLS_STRONG)) begin
          strong_near = 1'b1;
        end
      end
    end
    is_edge = (nw[1][1] == hyst3_pkg::CLS_STRONG) ||
              ((nw[1][1] == hyst3_pkg::CLS_WEAK) && strong_near);
  end

  assign push       = s1.valid && s1.emit;
  assign push_value = is_edge ? hyst3_pkg::EDGE_VALUE : hyst3_pkg::BACK_VALUE;
  assign push_last  = s1.last;

endmodule
`default_nettype wire

// ===== rtl/hyst3_obuf.sv =====
// Small result queue that decouples the pixel pipeline from the output consumer.
// Depends on hyst3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hyst3_obuf (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire logic [hyst3_pkg::PIX_W-1:0]  push_value,
  input  wire logic                         push_last,
  output logic                              in_ready,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [hyst3_pkg::PIX_W-1:0]  out_value,
  output logic                              frame_last
);

  localparam int PTR_W = $clog2(hyst3_pkg::OBUF_DEPTH);
  localparam int CNT_W = $clog2(hyst3_pkg::OBUF_DEPTH + 1);

  logic [hyst3_pkg::PIX_W-1:0] q_value [hyst3_pkg::OBUF_DEPTH];
  logic                        q_last  [hyst3_pkg::OBUF_DEPTH];
  logic [PTR_W-1:0]            wr_ptr;
  logic [PTR_W-1:0]            rd_ptr;
  logic [CNT_W-1:0]            count;
  logic                        pop;
  logic [CNT_W:0]              booked;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_value = q_value[rd_ptr];
  assign frame_last = q_last[rd_ptr];

  // Reserve room for the request still in the window stage.
  assign booked   = {1'b0, count} + (CNT_W + 1)'(push);
  assign in_ready = booked < (CNT_W + 1)'(hyst3_pkg::OBUF_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(hyst3_pkg::OBUF_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(hyst3_pkg::OBUF_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_value[wr_ptr] <= push_value;
      q_last[wr_ptr]  <= push_last;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hysteresis_threshold_3x3_top.sv =====
// Top level of the 3x3 hysteresis threshold block.
// Depends on hyst3_pkg, hyst3_line_ram, hyst3_pos, hyst3_win and hyst3_obuf.
//
// Streams a raster of 8-bit samples in scan order, one request per pixel, and
// returns one binary pixel per position: 0 for an edge, 255 otherwise. A
// sample below low_threshold is low, one above high_threshold (or equal to
// 255) is strong, anything else is weak; strong pixels are edges and weak
// pixels become edges when one of their eight in-frame neighbors is strong.
// The block takes one request per clock and keeps that rate as long as the
// consumer takes results; the bound is the line RAM, which sees one read and
// one write per pixel through its two ports. A result passes the window stage
// register into the queue after the request that completes its window; that
// request sits line_length+1 positions after the pixel in scan order, so after
// the last pixel of a frame send line_length+1 flush requests (mode = 1) to
// drain; accepting the request behind frame_last restarts the position
// counters. A flush at the very start of a frame is dropped. The two previous
// lines of classes live in one 1024 x 4 line RAM read and rewritten at the
// current column; there is no clearing pass after reset, since entries that
// were never written only reach window positions that lie outside the frame.
// Write the configuration registers only while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none
module hysteresis_threshold_3x3_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [hyst3_pkg::REG_IDX_W-1:0]  cfg_addr,
  input  wire logic [hyst3_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             mode,
  input  wire logic [hyst3_pkg::PIX_W-1:0]      pixel_value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [hyst3_pkg::PIX_W-1:0]      out_value,
  output logic                                  frame_last
);

  // Configuration registers.
  logic [hyst3_pkg::PIX_W-1:0] low_threshold;
  logic [hyst3_pkg::PIX_W-1:0] high_threshold;
  logic [hyst3_pkg::LEN_W-1:0] line_length;
  logic [hyst3_pkg::CNT_W-1:0] line_count;

  logic                          accept;
  hyst3_pkg::req_t               req;
  logic [hyst3_pkg::LINE_W-1:0]  ram_rdata;
  logic                          ram_we;
  logic [hyst3_pkg::COL_W-1:0]   ram_waddr;
  logic [hyst3_pkg::LINE_W-1:0]  ram_wdata;
  logic                          push;
  logic [hyst3_pkg::PIX_W-1:0]   push_value;
  logic                          push_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold  <= hyst3_pkg::RST_LOW_THRESHOLD;
      high_threshold <= hyst3_pkg::RST_HIGH_THRESHOLD;
      line_length    <= hyst3_pkg::RST_LINE_LENGTH;
      line_count     <= hyst3_pkg::RST_LINE_COUNT;
    end else if (cfg_we) begin
      case (cfg_addr)
        hyst3_pkg::REG_LOW_THRESHOLD:  low_threshold  <= cfg_data[hyst3_pkg::PIX_W-1:0];
        hyst3_pkg::REG_HIGH_THRESHOLD: high_threshold <= cfg_data[hyst3_pkg::PIX_W-1:0];
        hyst3_pkg::REG_LINE_LENGTH:    line_length    <= cfg_data[hyst3_pkg::LEN_W-1:0];
        hyst3_pkg::REG_LINE_COUNT:     line_count     <= cfg_data[hyst3_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept = in_valid && in_ready;

  // Stage 0: advance positions, class the pixel, issue the line RAM read.
  hyst3_pos u_pos (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .mode           (mode),
    .pixel_value    (pixel_value),
    .low_threshold  (low_threshold),
    .high_threshold (high_threshold),
    .line_length    (line_length),
    .line_count     (line_count),
    .req            (req)
  );

  hyst3_line_ram #(
    .DEPTH (hyst3_pkg::MAX_LINE_LENGTH),
    .WIDTH (hyst3_pkg::LINE_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (req.valid),
    .raddr (req.col),
    .rdata (ram_rdata)
  );

  // Stage 1: write back the shifted column, slide the window, decide the edge.
  hyst3_win u_win (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .ram_rdata  (ram_rdata),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .push       (push),
    .push_value (push_value),
    .push_last  (push_last)
  );

  // Hold results until the consumer takes them; drop ready before the queue fills, keeping room for results in flight.
  hyst3_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_value (push_value),
    .push_last  (push_last),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .frame_last (frame_last)
  );

endmodule
`default_nettype wire

// ===== rtl/hyst3_chk.sv =====
// Port-level checker for the hysteresis threshold block, bound to the top level.
// Depends on hyst3_pkg and hysteresis_threshold_3x3_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "hysteresis_threshold_3x3_top_assert.svh"
module hyst3_chk (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [hyst3_pkg::PIX_W-1:0]      out_value,
  input wire logic                             frame_last
);

  // Results are pure black or white.
  `HT3_ASSERT_NOW(a_binary_value, out_valid,
    (out_value == hyst3_pkg::EDGE_VALUE) || (out_value == hyst3_pkg::BACK_VALUE))
  // Backpressure on the input only comes from results piling up at the output.
  `HT3_ASSERT_NOW(a_stall_has_cause, !in_ready, out_valid)
  // A stalled result stays offered with the same payload.
  `HT3_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_value) && $stable(frame_last))
  // Reset flushes every pending result.
  `HT3_ASSERT_ALWAYS(a_reset_empty, rst, !out_valid)

endmodule

bind hysteresis_threshold_3x3_top hyst3_chk u_chk (.*);
`default_nettype wire
